@@ design/ogw_pkg.sv @@
package ogw_pkg;

   // Panel geometry default; addresses are always carried on 7 bits
   localparam int PANEL_SIZE_DEFAULT = 128;
   localparam int ADDR_W             = 7;
   localparam int PIXEL_W            = 16;

   // Command byte codes
   localparam logic [7:0] CMD_COLUMN = 8'h15;
   localparam logic [7:0] CMD_ROW    = 8'h75;
   localparam logic [7:0] CMD_REMAP  = 8'ha0;
   localparam logic [7:0] CMD_WRITE  = 8'h5c;
   localparam logic [7:0] CMD_OFF    = 8'hae;
   localparam logic [7:0] CMD_ON     = 8'haf;
   localparam logic [7:0] CMD_LEVEL  = 8'hc7;
   localparam logic [7:0] CMD_NONE   = 8'h00;

   // Argument positions within a command
   localparam logic [1:0] ARG_FIRST  = 2'd0;
   localparam logic [1:0] ARG_SECOND = 2'd1;
   localparam logic [1:0] ARG_SAT    = 2'd3;

   // Brightness after reset
   localparam logic [3:0] LEVEL_RESET = 4'hf;

   // Queue between the decode front and the execute back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operations handed from the front to the back
   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_PANEL_OFF = 4'd1,
      OP_PANEL_ON  = 4'd2,
      OP_COL_START = 4'd3,
      OP_COL_END   = 4'd4,
      OP_ROW_START = 4'd5,
      OP_ROW_END   = 4'd6,
      OP_REMAP     = 4'd7,
      OP_LEVEL     = 4'd8,
      OP_PIXEL     = 4'd9
   } ogw_opcode_type;

   typedef struct packed {
      ogw_opcode_type       op;
      logic [PIXEL_W-1:0]   data;
   } ogw_entry_type;

endpackage

@@ design/ogw_req_if.sv @@
interface ogw_req_if;
   logic       valid;
   logic       ready;
   logic       is_data;
   logic [7:0] byte_value;

   modport source (output valid, output is_data, output byte_value, input ready);
   modport sink   (input valid, input is_data, input byte_value, output ready);
endinterface

@@ design/ogw_rsp_if.sv @@
interface ogw_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [6:0]  write_column;
   logic [6:0]  write_row;
   logic [15:0] write_pixel;
   logic        panel_on;
   logic [3:0]  master_level;

   modport source (output valid, output write_valid, output write_column, output write_row,
                   output write_pixel, output panel_on, output master_level, input ready);
   modport sink   (input valid, input write_valid, input write_column, input write_row,
                   input write_pixel, input panel_on, input master_level, output ready);
endinterface

@@ design/ogw_front.sv @@
module ogw_front import ogw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ogw_req_if.sink       req,
   input  logic          queue_full,
   output logic          push_valid,
   output ogw_entry_type push_entry
);

   logic [7:0] last_command_ff, last_command_in;
   logic [1:0] arg_index_ff,    arg_index_in;
   logic       pending_ff,      pending_in;
   logic [7:0] held_ff,         held_in;
   logic       accept;

   assign req.ready  = !queue_full;
   assign accept     = req.valid && !queue_full;
   assign push_valid = accept;

   // Classify the incoming word against the command it belongs to
   always_comb begin
      last_command_in = last_command_ff;
      arg_index_in    = arg_index_ff;
      pending_in      = pending_ff;
      held_in         = held_ff;
      push_entry.op   = OP_NONE;
      push_entry.data = {8'h00, req.byte_value};
      if (!req.is_data) begin
         last_command_in = req.byte_value;
         arg_index_in    = ARG_FIRST;
         pending_in      = 1'b0;
         if (req.byte_value == CMD_OFF) begin
            push_entry.op = OP_PANEL_OFF;
         end else if (req.byte_value == CMD_ON) begin
            push_entry.op = OP_PANEL_ON;
         end
      end else begin
         case (last_command_ff)
            CMD_COLUMN: begin
               if (arg_index_ff == ARG_FIRST) begin
                  push_entry.op = OP_COL_START;
               end else if (arg_index_ff == ARG_SECOND) begin
                  push_entry.op = OP_COL_END;
               end
            end
            CMD_ROW: begin
               if (arg_index_ff == ARG_FIRST) begin
                  push_entry.op = OP_ROW_START;
               end else if (arg_index_ff == ARG_SECOND) begin
                  push_entry.op = OP_ROW_END;
               end
            end
            CMD_REMAP: begin
               if (arg_index_ff == ARG_FIRST) begin
                  push_entry.op = OP_REMAP;
               end
            end
            CMD_LEVEL: begin
               if (arg_index_ff == ARG_FIRST) begin
                  push_entry.op = OP_LEVEL;
               end
            end
            CMD_WRITE: begin
               // pair high and low bytes into one pixel
               if (pending_ff) begin
                  push_entry.op   = OP_PIXEL;
                  push_entry.data = {held_ff, req.byte_value};
                  pending_in      = 1'b0;
               end else begin
                  held_in    = req.byte_value;
                  pending_in = 1'b1;
               end
            end
            default: begin
               push_entry.op = OP_NONE;
            end
         endcase
         if (arg_index_ff != ARG_SAT) begin
            arg_index_in = arg_index_ff + 2'd1;
         end
      end
   end

   // Hold decode state; advance only on an accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         last_command_ff <= CMD_NONE;
         arg_index_ff    <= ARG_FIRST;
         pending_ff      <= 1'b0;
         held_ff         <= 8'h00;
      end else if (accept) begin
         last_command_ff <= last_command_in;
         arg_index_ff    <= arg_index_in;
         pending_ff      <= pending_in;
         held_ff         <= held_in;
      end
   end

endmodule

@@ design/ogw_queue.sv @@
module ogw_queue import ogw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  ogw_entry_type push_entry,
   output logic          full,
   output logic          pop_valid,
   output ogw_entry_type pop_entry,
   input  logic          pop
);

   ogw_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // Track fill level
   always_comb begin
      case ({push_valid, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ design/ogw_back.sv @@
module ogw_back import ogw_pkg::*; #(
   parameter int PANEL_SIZE = PANEL_SIZE_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   input  ogw_entry_type pop_entry,
   output logic          pop,
   ogw_rsp_if.source     rsp
);

   localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(PANEL_SIZE - 1);

   logic [ADDR_W-1:0] col_start_ff, col_start_in, col_end_ff, col_end_in;
   logic [ADDR_W-1:0] row_start_ff, row_start_in, row_end_ff, row_end_in;
   logic [ADDR_W-1:0] col_ptr_ff, col_ptr_in, row_ptr_ff, row_ptr_in;
   logic              vfirst_ff, vfirst_in;
   logic              panel_ff, panel_in;
   logic [3:0]        level_ff, level_in;

   logic                rsp_valid_ff;
   logic                wr_valid_ff, wr_valid_in;
   logic [ADDR_W-1:0]   wr_col_ff, wr_col_in, wr_row_ff, wr_row_in;
   logic [PIXEL_W-1:0]  wr_pix_ff, wr_pix_in;

   logic [ADDR_W-1:0] addr_lim;
   logic              col_wrap, row_wrap;
   logic [ADDR_W-1:0] col_step, row_step;
   logic              fire;

   assign fire = pop_valid && (!rsp_valid_ff || rsp.ready);
   assign pop  = fire;

   // Limit an address argument to the panel
   assign addr_lim = (pop_entry.data[ADDR_W-1:0] > ADDR_MAX) ? ADDR_MAX
                                                             : pop_entry.data[ADDR_W-1:0];

   // Single pointer steps, wrapping at or beyond the end
   assign col_wrap = (col_ptr_ff >= col_end_ff);
   assign row_wrap = (row_ptr_ff >= row_end_ff);
   assign col_step = col_wrap ? col_start_ff : col_ptr_ff + ADDR_W'(1);
   assign row_step = row_wrap ? row_start_ff : row_ptr_ff + ADDR_W'(1);

   // Execute one operation
   always_comb begin
      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      row_start_in = row_start_ff;
      row_end_in   = row_end_ff;
      col_ptr_in   = col_ptr_ff;
      row_ptr_in   = row_ptr_ff;
      vfirst_in    = vfirst_ff;
      panel_in     = panel_ff;
      level_in     = level_ff;
      wr_valid_in  = 1'b0;
      wr_col_in    = '0;
      wr_row_in    = '0;
      wr_pix_in    = '0;
      case (pop_entry.op)
         OP_PANEL_OFF: panel_in = 1'b0;
         OP_PANEL_ON:  panel_in = 1'b1;
         OP_COL_START: begin
            col_start_in = addr_lim;
            col_ptr_in   = addr_lim;
         end
         OP_COL_END:   col_end_in = addr_lim;
         OP_ROW_START: begin
            row_start_in = addr_lim;
            row_ptr_in   = addr_lim;
         end
         OP_ROW_END:   row_end_in = addr_lim;
         OP_REMAP:     vfirst_in  = pop_entry.data[0];
         OP_LEVEL:     level_in   = pop_entry.data[3:0];
         OP_PIXEL: begin
            wr_valid_in = 1'b1;
            wr_col_in   = col_ptr_ff;
            wr_row_in   = row_ptr_ff;
            wr_pix_in   = pop_entry.data;
            if (vfirst_ff) begin
               row_ptr_in = row_step;
               if (row_wrap) begin
                  col_ptr_in = col_step;
               end
            end else begin
               col_ptr_in = col_step;
               if (col_wrap) begin
                  row_ptr_in = row_step;
               end
            end
         end
         default: begin
            wr_valid_in = 1'b0;
         end
      endcase
   end

   // Hold window, pointers and panel state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_start_ff <= '0;
         col_end_ff   <= ADDR_MAX;
         row_start_ff <= '0;
         row_end_ff   <= ADDR_MAX;
         col_ptr_ff   <= '0;
         row_ptr_ff   <= '0;
         vfirst_ff    <= 1'b0;
         panel_ff     <= 1'b0;
         level_ff     <= LEVEL_RESET;
      end else if (fire) begin
         col_start_ff <= col_start_in;
         col_end_ff   <= col_end_in;
         row_start_ff <= row_start_in;
         row_end_ff   <= row_end_in;
         col_ptr_ff   <= col_ptr_in;
         row_ptr_ff   <= row_ptr_in;
         vfirst_ff    <= vfirst_in;
         panel_ff     <= panel_in;
         level_ff     <= level_in;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         wr_valid_ff <= wr_valid_in;
         wr_col_ff   <= wr_col_in;
         wr_row_ff   <= wr_row_in;
         wr_pix_ff   <= wr_pix_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.write_valid  = wr_valid_ff;
   assign rsp.write_column = wr_col_ff;
   assign rsp.write_row    = wr_row_ff;
   assign rsp.write_pixel  = wr_pix_ff;
   assign rsp.panel_on     = panel_ff;
   assign rsp.master_level = level_ff;

endmodule

@@ design/oled_gram_window_writer_unit.sv @@
// Flow: a word accepted at the input is stored in the queue, then executed by the
// back end, which registers its result word in the output register.
// Throughput: one word per cycle while results are taken; a two-entry queue
// between decode and execute keeps input accepted while a result waits on output.
// Reset (synchronous): window opens to the full panel, pointers to 0, display off,
// brightness 15, queue and output emptied.
module oled_gram_window_writer_unit import ogw_pkg::*; #(
   parameter int PANEL_SIZE = PANEL_SIZE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ogw_req_if.sink   req_ch,
   ogw_rsp_if.source rsp_ch
);

   logic          push_valid;
   ogw_entry_type push_entry;
   logic          queue_full;
   logic          pop_valid;
   ogw_entry_type pop_entry;
   logic          pop;

   ogw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   ogw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   ogw_back #(
      .PANEL_SIZE (PANEL_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("push into full queue");

   // Every executed operation shows up as a result word next cycle
   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_valid) |=> rsp_ch.valid)
      else $error("executed operation produced no result");

   // A result without a pixel write carries zero address and pixel
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.write_valid) |->
         (rsp_ch.write_column == 7'd0 && rsp_ch.write_row == 7'd0 &&
          rsp_ch.write_pixel == 16'd0))
      else $error("non-write result carries address or pixel");

   // Only a pixel operation produces a write
   a_write_from_pixel: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_valid && pop_entry.op != OP_PIXEL) |=> !rsp_ch.write_valid)
      else $error("write without a pixel operation");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import ogw_pkg::*;

   localparam int          LIMIT_CYCLES  = 200000;
   localparam int          RANDOM_BYTES  = 1600;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          DRAIN_CYCLES  = 8;
   localparam logic [ADDR_W-1:0] ADDR_MAX =
      ADDR_W'((PANEL_SIZE_DEFAULT - 1) & ((1 << ADDR_W) - 1));

   typedef struct packed {
      logic       is_data;
      logic [7:0] byte_value;
   } serial_byte_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_column;
      logic [ADDR_W-1:0] write_row;
      logic [PIXEL_W-1:0] write_pixel;
      logic              panel_on;
      logic [3:0]        master_level;
   } gram_write_type;

   logic clock;
   logic reset;

   ogw_req_if req_bus ();
   ogw_rsp_if rsp_bus ();

   oled_gram_window_writer_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   serial_byte_type pending_bytes[$];
   gram_write_type  expected_writes[$];

   int total_bytes;
   int bytes_accepted;
   int words_checked;
   int pixels_seen;
   int error_count;
   int cycle_count;
   int hold_left;
   bit hold_done;

   // controller state as the testbench sees it
   logic [7:0]        last_cmd;
   logic [1:0]        arg_idx;
   logic [ADDR_W-1:0] col_start, col_end, row_start, row_end, col_ptr, row_ptr;
   logic              vert_first;
   logic              hi_pending;
   logic [7:0]        hi_byte;
   logic              panel_flag;
   logic [3:0]        level;

   // generator bookkeeping
   logic [7:0] gen_command;
   int         counted_bytes;

   always #5 clock = ~clock;

   function automatic logic [ADDR_W-1:0] clamp_addr(input logic [7:0] b);
      logic [ADDR_W-1:0] a;
      a = b[ADDR_W-1:0];
      if (a > ADDR_MAX) a = ADDR_MAX;
      return a;
   endfunction

   // wrap to the start once at or past the end, so an end below the start pins the pointer
   function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p,
                                                  input logic [ADDR_W-1:0] first,
                                                  input logic [ADDR_W-1:0] last);
      if (p >= last) return first;
      return p + ADDR_W'(1);
   endfunction

   function automatic gram_write_type predict_write(input logic is_data, input logic [7:0] b);
      gram_write_type r;
      logic           wrapped;
      r = '0;
      if (!is_data) begin
         last_cmd   = b;
         arg_idx    = ARG_FIRST;
         hi_pending = 1'b0;
         if (b == CMD_OFF) panel_flag = 1'b0;
         else if (b == CMD_ON) panel_flag = 1'b1;
      end else begin
         case (last_cmd)
            CMD_COLUMN: begin
               if (arg_idx == ARG_FIRST) begin
                  col_start = clamp_addr(b);
                  col_ptr   = col_start;
               end else if (arg_idx == ARG_SECOND) begin
                  col_end = clamp_addr(b);
               end
            end
            CMD_ROW: begin
               if (arg_idx == ARG_FIRST) begin
                  row_start = clamp_addr(b);
                  row_ptr   = row_start;
               end else if (arg_idx == ARG_SECOND) begin
                  row_end = clamp_addr(b);
               end
            end
            CMD_REMAP: begin
               if (arg_idx == ARG_FIRST) vert_first = b[0];
            end
            CMD_LEVEL: begin
               if (arg_idx == ARG_FIRST) level = b[3:0];
            end
            CMD_WRITE: begin
               if (!hi_pending) begin
                  hi_byte    = b;
                  hi_pending = 1'b1;
               end else begin
                  r.write_valid  = 1'b1;
                  r.write_column = col_ptr;
                  r.write_row    = row_ptr;
                  r.write_pixel  = {hi_byte, b};
                  hi_pending     = 1'b0;
                  // advance the running pointer, carry into the other one on wrap
                  if (vert_first) begin
                     wrapped = (row_ptr >= row_end);
                     row_ptr = next_ptr(row_ptr, row_start, row_end);
                     if (wrapped) col_ptr = next_ptr(col_ptr, col_start, col_end);
                  end else begin
                     wrapped = (col_ptr >= col_end);
                     col_ptr = next_ptr(col_ptr, col_start, col_end);
                     if (wrapped) row_ptr = next_ptr(row_ptr, row_start, row_end);
                  end
               end
            end
            default: ;
         endcase
         if (arg_idx != ARG_SAT) arg_idx = arg_idx + 2'd1;
      end
      r.panel_on     = panel_flag;
      r.master_level = level;
      return r;
   endfunction

   task automatic add_command(input logic [7:0] code);
      serial_byte_type w;
      w.is_data    = 1'b0;
      w.byte_value = code;
      pending_bytes.push_back(w);
      gen_command = code;
      counted_bytes++;
   endtask

   task automatic add_data(input logic [7:0] b);
      serial_byte_type w;
      w.is_data    = 1'b1;
      w.byte_value = b;
      pending_bytes.push_back(w);
      // data after a command without arguments is dropped by the block
      if (gen_command == CMD_COLUMN || gen_command == CMD_ROW || gen_command == CMD_REMAP ||
          gen_command == CMD_LEVEL || gen_command == CMD_WRITE)
         counted_bytes++;
   endtask

   // random window start and optional end byte: mostly small windows so the pointers wrap often
   task automatic add_window(input logic [7:0] code, input bit both_args);
      logic [7:0] first;
      int         last;
      int         pick;
      first = 8'($urandom_range(0, 255));
      pick  = $urandom_range(0, 99);
      if (pick < 10) begin
         first = 8'h00;
         last  = ADDR_MAX;
      end else if (pick < 85) begin
         last = first[ADDR_W-1:0] + $urandom_range(0, 9);
         if (last > ADDR_MAX) last = ADDR_MAX;
         last = last | ($urandom_range(0, 1) << 7);
      end else begin
         last = $urandom_range(0, 255);
      end
      add_command(code);
      add_data(first);
      if (both_args) add_data(last[7:0]);
   endtask

   function automatic int idle_phase();
      if (bytes_accepted < total_bytes / 3) return 0;
      if (bytes_accepted < (2 * total_bytes) / 3) return 1;
      return 2;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // drive request words; predict each one as it is taken
   always @(posedge clock) begin : drive_bytes
      serial_byte_type w;
      int              idle_pct;
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.is_data    <= 1'b0;
         req_bus.byte_value <= 8'h00;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_writes.push_back(predict_write(req_bus.is_data, req_bus.byte_value));
            bytes_accepted++;
         end
         case (idle_phase())
            0:       idle_pct = 14;
            1:       idle_pct = 60;
            default: idle_pct = 0;
         endcase
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               w = pending_bytes.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.is_data    <= w.is_data;
               req_bus.byte_value <= w.byte_value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long output hold-off once, late in the run, while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && bytes_accepted >= (5 * total_bytes) / 6) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // take result words and compare against the oldest prediction
   always @(posedge clock) begin : take_writes
      gram_write_type want;
      int             idle_pct;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_writes.size() == 0) begin
               $error("result word with no prediction waiting");
               error_count++;
            end else begin
               want = expected_writes.pop_front();
               check_field("write_valid", want.write_valid, rsp_bus.write_valid);
               check_field("write_column", want.write_column, rsp_bus.write_column);
               check_field("write_row", want.write_row, rsp_bus.write_row);
               check_field("write_pixel", want.write_pixel, rsp_bus.write_pixel);
               check_field("panel_on", want.panel_on, rsp_bus.panel_on);
               check_field("master_level", want.master_level, rsp_bus.master_level);
               if (rsp_bus.write_valid) pixels_seen++;
               words_checked++;
            end
         end
         case (idle_phase())
            0:       idle_pct = 60;
            1:       idle_pct = 14;
            default: idle_pct = 0;
         endcase
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d words still predicted",
                  cycle_count, expected_writes.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : run_stimulus
      int pick;
      int count;
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.is_data    = 1'b0;
      req_bus.byte_value = 8'h00;
      rsp_bus.ready      = 1'b0;
      bytes_accepted     = 0;
      words_checked      = 0;
      pixels_seen        = 0;
      error_count        = 0;
      cycle_count        = 0;
      counted_bytes      = 0;
      gen_command        = CMD_NONE;
      total_bytes        = 1 << 30;

      // state after reset
      last_cmd   = CMD_NONE;
      arg_idx    = ARG_FIRST;
      col_start  = '0;
      col_end    = ADDR_MAX;
      row_start  = '0;
      row_end    = ADDR_MAX;
      col_ptr    = '0;
      row_ptr    = '0;
      vert_first = 1'b0;
      hi_pending = 1'b0;
      hi_byte    = 8'h00;
      panel_flag = 1'b0;
      level      = LEVEL_RESET;

      // directed: on/off, lowest level, vertical remap, masked window with end below start,
      // extreme pixels, high byte dropped by a command, unknown command, saturating arguments
      add_command(CMD_ON);
      add_command(CMD_LEVEL);
      add_data(8'hf0);
      add_command(CMD_REMAP);
      add_data(8'h01);
      add_command(CMD_COLUMN);
      add_data(8'hfe);
      add_data(8'h80);
      add_command(CMD_ROW);
      add_data(8'h7d);
      add_data(8'hff);
      add_command(CMD_WRITE);
      add_data(8'hff);
      add_data(8'hff);
      add_data(8'h00);
      add_data(8'h00);
      add_data(8'h12);
      add_command(CMD_OFF);
      add_command(8'h3c);
      add_data(8'h55);
      add_command(CMD_REMAP);
      add_data(8'h00);
      add_data(8'h01);
      add_data(8'h01);
      add_data(8'h01);

      // random: mostly window setup followed by pixel bursts, with some noise
      counted_bytes = 0;
      while (counted_bytes < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            add_window(CMD_COLUMN, $urandom_range(0, 9) != 0);
            if ($urandom_range(0, 1)) add_window(CMD_ROW, $urandom_range(0, 9) != 0);
         end else if (pick < 60) begin
            add_command(CMD_WRITE);
            count = 2 * $urandom_range(1, 30);
            if ($urandom_range(0, 9) == 0) count = count - 1;
            repeat (count) add_data(8'($urandom_range(0, 255)));
         end else if (pick < 70) begin
            add_command(CMD_REMAP);
            repeat ($urandom_range(1, 4)) add_data(8'($urandom_range(0, 255)));
         end else if (pick < 80) begin
            add_command(CMD_LEVEL);
            repeat ($urandom_range(1, 4)) add_data(8'($urandom_range(0, 255)));
         end else if (pick < 88) begin
            add_command($urandom_range(0, 1) ? CMD_ON : CMD_OFF);
         end else begin
            add_command(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) add_data(8'($urandom_range(0, 255)));
         end
      end
      total_bytes = pending_bytes.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait for every word to go in and every prediction to be met
      while (pending_bytes.size() != 0 || req_bus.valid || expected_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_writes.size() != 0) begin
         $error("%0d predicted words never arrived", expected_writes.size());
         error_count++;
      end
      $display("%0d bytes sent, %0d result words checked, %0d pixels written",
               bytes_accepted, words_checked, pixels_seen);
      $display("covered window clamping and wrap, both scan orders, on/off, level and stalls");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
